// File: src/kmc_pkg.sv
`timescale 1ns / 1ps
package kmc_pkg;
  localparam int MaxClusters = 16;
  localparam int CountBits   = 24;
  localparam int IdxBits     = 4;

  localparam logic [1:0] REQ_SET   = 2'd0;
  localparam logic [1:0] REQ_PIXEL = 2'd1;
  localparam logic [1:0] REQ_END   = 2'd2;

  localparam logic RES_PIXEL  = 1'b0;
  localparam logic RES_REPORT = 1'b1;

  typedef struct packed {
    logic [1:0] req_type;
    logic [3:0] cluster_index;
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } req_t;

  typedef struct packed {
    logic       result_kind;
    logic [3:0] assigned_index;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       any_changed;
    logic       pass_overflow;
  } res_t;

  // controller -> datapath
  typedef struct packed {
    logic       load;      // latch request
    logic       set_cent;  // write centroid slot
    logic       cmp_step;  // compare centroid at idx
    logic       acc;       // accumulate pixel into best
    logic       div_start; // start divide for cluster idx
    logic       clear;     // clear accumulator idx
    logic       emit_pix;
    logic       emit_end;
    logic       clr_flags;
    logic [IdxBits-1:0] idx;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic div_busy;
    logic cnt_zero;
  } sts_t;
endpackage

// File: src/kmc_div.sv
`timescale 1ns / 1ps
module kmc_div
  import kmc_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic [31:0]          num,
  input  logic [CountBits-1:0] den,
  output logic                 busy,
  output logic [31:0]          quo
);
  // restoring divider, one quotient bit per cycle
  logic [CountBits:0]   rem;
  logic [5:0]           cnt;
  logic [CountBits:0]   trial;

  assign trial = {rem[CountBits-1:0], quo[31]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= 6'd32;
      rem  <= '0;
      quo  <= num;
    end else if (busy) begin
      if (trial >= {1'b0, den}) begin
        rem <= trial - {1'b0, den};
        quo <= {quo[30:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[30:0], 1'b0};
      end
      cnt <= cnt - 6'd1;
      if (cnt == 6'd1) busy <= 1'b0;
    end
  end
endmodule

// File: src/kmc_datapath.sv
`timescale 1ns / 1ps
module kmc_datapath
  import kmc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  input  req_t req,
  output sts_t sts,
  output logic [1:0] cur_type,
  output res_t res
);
  localparam logic [31:0] SumMax = '1;
  localparam logic [CountBits-1:0] CntMax = '1;

  req_t r;
  logic [23:0] cent [MaxClusters];
  logic [31:0] sr [MaxClusters];
  logic [31:0] sg [MaxClusters];
  logic [31:0] sb [MaxClusters];
  logic [CountBits-1:0] cnt [MaxClusters];
  logic ovf, moved;
  logic [IdxBits-1:0] best;
  logic [17:0] best_d;
  logic [1:0]  ch;
  logic [IdxBits-1:0] didx;
  logic [7:0] m_r, m_g;

  assign cur_type = r.req_type;

  // one centroid distance per cycle
  logic [23:0] c;
  logic [8:0] dr, dg, db;
  logic [7:0] ar, ag, ab;
  logic [17:0] d;
  always_comb begin
    c  = cent[cmd.idx];
    dr = {1'b0, c[23:16]} - {1'b0, r.red};
    dg = {1'b0, c[15:8]} - {1'b0, r.green};
    db = {1'b0, c[7:0]} - {1'b0, r.blue};
    ar = dr[8] ? 8'(-dr) : dr[7:0];
    ag = dg[8] ? 8'(-dg) : dg[7:0];
    ab = db[8] ? 8'(-db) : db[7:0];
    d  = 18'({8'd0, ar} * {8'd0, ar}) + 18'({8'd0, ag} * {8'd0, ag}) +
         18'({8'd0, ab} * {8'd0, ab});
  end

  // shared divider, three channels in turn
  logic        dstart, dbusy;
  logic [31:0] dnum, dq;
  logic [7:0]  mq;
  always_comb begin
    case (ch)
      2'd0:    dnum = sr[didx];
      2'd1:    dnum = sg[didx];
      default: dnum = sb[didx];
    endcase
  end
  assign mq = (dq > 32'd255) ? 8'hFF : dq[7:0];

  logic dbusy_q, ddone;
  kmc_div u_div (
    .clk(clk), .rst(rst), .start(dstart), .num(dnum), .den(cnt[didx]),
    .busy(dbusy), .quo(dq)
  );
  assign ddone = dbusy_q && !dbusy;
  assign sts.div_busy = dstart || dbusy || (ch != 2'd0) || ddone;
  assign sts.cnt_zero = (cnt[cmd.idx] == '0);

  logic [32:0] ar2, ag2, ab2;
  assign ar2 = {1'b0, sr[best]} + 33'(r.red);
  assign ag2 = {1'b0, sg[best]} + 33'(r.green);
  assign ab2 = {1'b0, sb[best]} + 33'(r.blue);

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MaxClusters; i++) begin
        cent[i] <= '0; sr[i] <= '0; sg[i] <= '0; sb[i] <= '0; cnt[i] <= '0;
      end
      ovf <= 1'b0; moved <= 1'b0; ch <= '0; dstart <= 1'b0; dbusy_q <= 1'b0;
      r <= '0; didx <= '0; best <= '0; best_d <= '0; res <= '0;
    end else begin
      // next channel starts as soon as the previous quotient is taken
      dstart  <= cmd.div_start || (ddone && ch != 2'd2);
      dbusy_q <= dbusy;
      if (cmd.load) r <= req;
      if (cmd.set_cent) cent[r.cluster_index] <= {r.red, r.green, r.blue};
      if (cmd.cmp_step) begin
        if (cmd.idx == '0 || d < best_d) begin
          best_d <= d;
          best   <= cmd.idx;
        end
      end
      if (cmd.acc) begin
        if (cnt[best] == CntMax) ovf <= 1'b1;
        else begin
          cnt[best] <= cnt[best] + 1'b1;
          sr[best] <= ar2[32] ? SumMax : ar2[31:0];
          sg[best] <= ag2[32] ? SumMax : ag2[31:0];
          sb[best] <= ab2[32] ? SumMax : ab2[31:0];
          if (ar2[32] || ag2[32] || ab2[32]) ovf <= 1'b1;
        end
      end
      if (cmd.div_start) begin
        didx <= cmd.idx; ch <= 2'd0;
      end
      if (ddone) begin
        case (ch)
          2'd0: begin m_r <= mq; ch <= 2'd1; end
          2'd1: begin m_g <= mq; ch <= 2'd2; end
          default: begin
            ch <= 2'd0;
            if ({m_r, m_g, mq} != cent[didx]) moved <= 1'b1;
            cent[didx] <= {m_r, m_g, mq};
          end
        endcase
      end
      if (cmd.clear) begin
        sr[cmd.idx] <= '0; sg[cmd.idx] <= '0; sb[cmd.idx] <= '0;
        cnt[cmd.idx] <= '0;
      end
      if (cmd.clr_flags) begin ovf <= 1'b0; moved <= 1'b0; end
      if (cmd.emit_pix) begin
        res <= '{result_kind: RES_PIXEL, assigned_index: best,
                 out_red: cent[best][23:16], out_green: cent[best][15:8],
                 out_blue: cent[best][7:0], any_changed: 1'b0, pass_overflow: 1'b0};
      end else if (cmd.emit_end) begin
        res <= '{result_kind: RES_REPORT, assigned_index: '0, out_red: '0,
                 out_green: '0, out_blue: '0, any_changed: moved, pass_overflow: ovf};
      end
    end
  end
endmodule

// File: src/kmc_ctrl.sv
`timescale 1ns / 1ps
module kmc_ctrl
  import kmc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       out_stall,
  output logic       out_valid,
  input  logic       cfg_we,
  input  logic [4:0] cfg_data,
  input  logic [1:0] cur_type,
  input  sts_t       sts,
  output cmd_t       cmd
);
  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_DEC   = 7'b0000010,
    S_CMP   = 7'b0000100,
    S_ACC   = 7'b0001000,
    S_UPD   = 7'b0010000,
    S_WAIT  = 7'b0100000,
    S_CLR   = 7'b1000000
  } state_t;

  state_t state, state_next;
  logic [IdxBits-1:0] idx, idx_next;
  logic [4:0] ncl;
  logic [IdxBits-1:0] last;
  logic clr_pend;
  logic out_free;

  always_comb begin
    if (ncl == 5'd0) last = '0;
    else if (ncl > 5'(MaxClusters)) last = IdxBits'(MaxClusters - 1);
    else last = IdxBits'(ncl - 5'd1);
  end

  // output register free, or emptied at this edge
  assign out_free = !out_valid || !out_stall;
  assign in_stall = (state != S_IDLE);

  always_comb begin
    cmd = '0;
    cmd.idx = idx;
    // flags clear the cycle after the report is captured
    cmd.clr_flags = clr_pend;
    state_next = state;
    idx_next = idx;
    unique case (state)
      S_IDLE: if (in_valid && !in_stall) begin
        cmd.load = 1'b1; state_next = S_DEC;
      end
      S_DEC: begin
        idx_next = '0;
        unique case (cur_type)
          REQ_SET:   begin cmd.set_cent = 1'b1; state_next = S_IDLE; end
          REQ_PIXEL: state_next = S_CMP;
          REQ_END:   state_next = S_UPD;
          default:   state_next = S_IDLE;
        endcase
      end
      S_CMP: begin
        cmd.cmp_step = 1'b1;
        if (idx == last) state_next = S_ACC;
        else idx_next = idx + 1'b1;
      end
      S_ACC: if (out_free) begin
        cmd.acc = 1'b1; cmd.emit_pix = 1'b1; state_next = S_IDLE;
      end
      S_UPD: begin
        if (!sts.cnt_zero) begin
          cmd.div_start = 1'b1; state_next = S_WAIT;
        end else if (idx == last) begin
          idx_next = '0; state_next = S_CLR;
        end else idx_next = idx + 1'b1;
      end
      S_WAIT: if (!sts.div_busy) begin
        if (idx == last) begin idx_next = '0; state_next = S_CLR; end
        else begin idx_next = idx + 1'b1; state_next = S_UPD; end
      end
      S_CLR: begin
        cmd.clear = 1'b1;
        if (idx == IdxBits'(MaxClusters - 1)) begin
          if (out_free) begin
            cmd.emit_end = 1'b1; state_next = S_IDLE;
          end
        end else idx_next = idx + 1'b1;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; idx <= '0; ncl <= 5'd1; out_valid <= 1'b0;
      clr_pend <= 1'b0;
    end else begin
      state <= state_next; idx <= idx_next;
      if (cfg_we) ncl <= cfg_data;
      clr_pend <= cmd.emit_end;
      if (cmd.emit_pix || cmd.emit_end) out_valid <= 1'b1;
      else if (!out_stall) out_valid <= 1'b0;
    end
  end
endmodule

// File: src/kmeans_rgb_cluster_pass.sv
`timescale 1ns / 1ps
// Set request: decoded, then its centroid slot is written. Pixel: the K clusters in use are
// compared in turn, then the result is registered. End of pass: each non-empty cluster's
// three channel means are divided in turn, empty ones skipped, and all 16 accumulators
// cleared. Throughput: one request at a time, the next taken once the last has finished;
// a stalled result waits in the output register and only holds back the next result.
// Reset (rst, synchronous) zeroes centroids, accumulators and flags, sets cluster count to 1.
module kmeans_rgb_cluster_pass
  import kmc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  req_t       in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output res_t       out_data,
  input  logic       cfg_we,
  input  logic [4:0] cfg_data
);
  cmd_t cmd;
  sts_t sts;
  logic [1:0] cur_type;

  // controller sequences requests; datapath holds all state
  kmc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_stall(out_stall), .out_valid(out_valid), .cfg_we(cfg_we),
    .cfg_data(cfg_data), .cur_type(cur_type), .sts(sts), .cmd(cmd)
  );

  kmc_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .req(in_data), .sts(sts),
    .cur_type(cur_type), .res(out_data)
  );
endmodule

// File: src/kmc_checker.sv
`timescale 1ns / 1ps
module kmc_checker
  import kmc_pkg::*;
(
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input res_t out_data
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("result dropped");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("second request taken");
  a_pix: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_data.result_kind |-> !out_data.any_changed && !out_data.pass_overflow)
    else $error("pixel flags");
  a_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.result_kind |-> out_data.assigned_index == '0)
    else $error("report index");
endmodule

bind kmeans_rgb_cluster_pass kmc_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
